// File: rtl/tpae_pkg.sv
// Shared types, constants and arithmetic helpers for the trivariate polynomial evaluator.
package tpae_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic CFG_ROW = 1'b0;
    localparam logic CFG_COL = 1'b1;

    localparam int NPOW    = 6;
    localparam int EXP_W   = 3;
    localparam int COEF_W  = 48;
    localparam int TERM_W  = 3 * EXP_W + COEF_W;
    localparam int ACC_W   = 58;
    localparam int CNT_W   = 9;

    localparam logic [EXP_W-1:0]  EXP_MAX = 3'd5;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef struct packed {
        logic                     cmd;
        logic [5:0]               term_index;
        logic [2:0]               x_exponent;
        logic [2:0]               y_exponent;
        logic [2:0]               z_exponent;
        logic signed [47:0]       coefficient;
        logic signed [31:0]       x_coord;
        logic signed [31:0]       y_coord;
        logic signed [31:0]       z_coord;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] line_delta;
        logic signed [47:0] sample_delta;
        logic               overflow;
    } t_out_item;

    typedef struct packed {
        logic       start;
        logic       pow_mul;
        logic       pow_rnd;
        logic [2:0] pow_k;
        logic       iss_vld;
        logic       iss_grp;
        logic       fin;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
    } t_dp_sts;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [47:0] mag48(input logic signed [47:0] v);
        return v[47] ? (~v + 48'd1) : v;
    endfunction

    function automatic logic signed [31:0] rnd_q30(input logic [63:0] p, input logic neg);
        logic [63:0] s;
        logic [33:0] q;
        s = p + 64'd536870912;
        q = s[63:30];
        if (neg) begin
            if (q > 34'h0_8000_0000) return 32'sh8000_0000;
            return ~q[31:0] + 32'd1;
        end
        if (q > 34'h0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        return q[31:0];
    endfunction

endpackage

// File: rtl/tpae_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpae_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tpae_dp.sv
// Datapath: power tables, per-term multiply pipeline, group accumulators and result register.
module tpae_dp import tpae_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  t_in_item          i_item,
    input  logic [TERM_W-1:0] i_rdata,
    output t_dp_sts           o_sts,
    output t_out_item         o_data
);

    logic signed [31:0] r_crd  [3];
    logic signed [31:0] r_prev [3];
    logic [63:0]        r_pp   [3];
    logic               r_pn   [3];
    logic signed [31:0] r_pw   [3][NPOW];

    logic [7:1] r_v;
    logic [7:1] r_g;

    logic [2:0]          ex, ey, ez;
    logic signed [31:0]  px, py;
    logic [63:0]         r_pxy;
    logic                r_nxy;
    logic signed [31:0]  r_pz2, r_pz3;
    logic signed [47:0]  r_cf2, r_cf3, r_cf4, r_cf5;
    logic signed [31:0]  r_m1, r_m;
    logic [63:0]         r_pm;
    logic                r_nm;
    logic [63:0]         r_ph, r_pl;
    logic                r_nt, r_nq;
    logic [48:0]         r_q;
    logic [31:0]         bm;
    logic [79:0]         tsum;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] r_acc_line, r_acc_smp;
    logic signed [47:0]  sat_line, sat_smp;
    logic                ovf_line, ovf_smp;
    t_out_item           r_out;

    assign ex = (i_rdata[2:0] > EXP_MAX) ? EXP_MAX : i_rdata[2:0];
    assign ey = (i_rdata[5:3] > EXP_MAX) ? EXP_MAX : i_rdata[5:3];
    assign ez = (i_rdata[8:6] > EXP_MAX) ? EXP_MAX : i_rdata[8:6];
    assign px = r_pw[0][ex];
    assign py = r_pw[1][ey];
    assign bm = mag32(r_m);
    assign tsum = {r_ph, 16'd0} + {16'd0, r_pl} + 80'd536870912;
    assign term = r_nq ? -$signed({9'd0, r_q}) : $signed({9'd0, r_q});

    always_comb begin
        ovf_line = 1'b0;
        ovf_smp  = 1'b0;
        sat_line = r_acc_line[47:0];
        sat_smp  = r_acc_smp[47:0];
        if (r_acc_line > $signed(ACC_W'(48'h7FFF_FFFF_FFFF))) begin
            sat_line = 48'sh7FFF_FFFF_FFFF;
            ovf_line = 1'b1;
        end else if (r_acc_line < -$signed(ACC_W'(48'h8000_0000_0000))) begin
            sat_line = 48'sh8000_0000_0000;
            ovf_line = 1'b1;
        end
        if (r_acc_smp > $signed(ACC_W'(48'h7FFF_FFFF_FFFF))) begin
            sat_smp = 48'sh7FFF_FFFF_FFFF;
            ovf_smp = 1'b1;
        end else if (r_acc_smp < -$signed(ACC_W'(48'h8000_0000_0000))) begin
            sat_smp = 48'sh8000_0000_0000;
            ovf_smp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_g <= '0;
        end else begin
            r_v <= {r_v[6:1], i_cmd.iss_vld};
            r_g <= {r_g[6:1], i_cmd.iss_grp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_crd[0] <= i_item.x_coord;
            r_crd[1] <= i_item.y_coord;
            r_crd[2] <= i_item.z_coord;
            for (int a = 0; a < 3; a++) begin
                r_prev[a]  <= ONE_Q30;
                r_pw[a][0] <= ONE_Q30;
            end
        end
        if (i_cmd.pow_mul) begin
            for (int a = 0; a < 3; a++) begin
                r_pp[a] <= 64'(mag32(r_prev[a])) * 64'(mag32(r_crd[a]));
                r_pn[a] <= r_prev[a][31] ^ r_crd[a][31];
            end
        end
        if (i_cmd.pow_rnd) begin
            for (int a = 0; a < 3; a++) begin
                r_pw[a][i_cmd.pow_k] <= rnd_q30(r_pp[a], r_pn[a]);
                r_prev[a]            <= rnd_q30(r_pp[a], r_pn[a]);
            end
        end

        r_pxy <= 64'(mag32(px)) * 64'(mag32(py));
        r_nxy <= px[31] ^ py[31];
        r_pz2 <= r_pw[2][ez];
        r_cf2 <= i_rdata[TERM_W-1:9];

        r_m1  <= rnd_q30(r_pxy, r_nxy);
        r_pz3 <= r_pz2;
        r_cf3 <= r_cf2;

        r_pm  <= 64'(mag32(r_m1)) * 64'(mag32(r_pz3));
        r_nm  <= r_m1[31] ^ r_pz3[31];
        r_cf4 <= r_cf3;

        r_m   <= rnd_q30(r_pm, r_nm);
        r_cf5 <= r_cf4;

        r_ph  <= 64'(mag48(r_cf5)) * 64'(bm[31:16]);
        r_pl  <= 64'(mag48(r_cf5)) * 64'(bm[15:0]);
        r_nt  <= r_cf5[47] ^ r_m[31];

        r_q   <= tsum[78:30];
        r_nq  <= r_nt;

        if (i_cmd.start) begin
            r_acc_line <= '0;
            r_acc_smp  <= '0;
        end else if (r_v[7]) begin
            if (r_g[7]) begin
                r_acc_smp <= r_acc_smp + term;
            end else begin
                r_acc_line <= r_acc_line + term;
            end
        end

        if (i_cmd.fin) begin
            r_out.line_delta   <= sat_line;
            r_out.sample_delta <= sat_smp;
            r_out.overflow     <= ovf_line | ovf_smp;
        end
    end

    assign o_sts.pipe_busy = |r_v;
    assign o_data          = r_out;

endmodule

// File: rtl/tpae_ctrl.sv
// Controller: handshakes, configuration registers and sequencing of power setup and term walk.
module tpae_ctrl import tpae_pkg::*; #(
    parameter int MAX_TERMS = 64,
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
    localparam int CW = $clog2(MAX_TERMS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_cmd_eval,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_idx,
    input  logic [6:0]    i_cfg_data,
    input  t_dp_sts       i_sts,
    output t_dp_cmd       o_cmd,
    output logic [AW-1:0] o_raddr
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_POW   = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_k, n_k;
    logic          r_ph, n_ph;
    logic [CW-1:0] r_i, n_i;
    logic [6:0]    r_nr, r_nc;
    logic          r_ovld, n_ovld;
    logic [CNT_W-1:0] sum, lim, i_ext;

    assign sum   = CNT_W'(r_nr) + CNT_W'(r_nc);
    assign lim   = (sum < MAX_CNT) ? sum : MAX_CNT;
    assign i_ext = CNT_W'(r_i);
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovld;
    assign o_raddr = r_i[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_ph    = r_ph;
        n_i     = r_i;
        n_ovld  = r_ovld && !i_ready;
        o_cmd   = '0;
        o_cmd.pow_k = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && i_cmd_eval) begin
                    o_cmd.start = 1'b1;
                    n_k     = 3'd1;
                    n_ph    = 1'b0;
                    n_state = ST_POW;
                end
            end
            ST_POW: begin
                if (!r_ph) begin
                    o_cmd.pow_mul = 1'b1;
                    n_ph = 1'b1;
                end else begin
                    o_cmd.pow_rnd = 1'b1;
                    n_ph = 1'b0;
                    if (r_k == EXP_MAX) begin
                        n_i     = '0;
                        n_state = ST_RUN;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            ST_RUN: begin
                if (i_ext < lim) begin
                    o_cmd.iss_vld = 1'b1;
                    o_cmd.iss_grp = (i_ext >= CNT_W'(r_nr));
                    n_i = r_i + CW'(1);
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_ovld || i_ready) begin
                    o_cmd.fin = 1'b1;
                    n_ovld    = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_ph    <= 1'b0;
            r_i     <= '0;
            r_ovld  <= 1'b0;
            r_nr    <= '0;
            r_nc    <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_ph    <= n_ph;
            r_i     <= n_i;
            r_ovld  <= n_ovld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROW: r_nr <= i_cfg_data;
                    CFG_COL: r_nc <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: rtl/trivariate_poly_adjust_eval.sv
// Top level of the sparse trivariate polynomial evaluator.
// A write beat stores one term. An evaluate beat walks N entries (line plus sample
// terms, at most MAX_TERMS) and loads its result into the output register; the next
// beat is taken once the controller is back in its idle state. The x, y and z power
// tables are built first, then one term per cycle streams from the term RAM through
// a seven-stage multiply pipeline into the two accumulators, and the pipeline drains
// before the result is saturated. A result that waits on the output holds the next
// result back; a write beat may be taken while that result still waits.
module trivariate_poly_adjust_eval import tpae_pkg::*; #(
    parameter int MAX_TERMS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_data,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [AW-1:0]     raddr;
    logic [TERM_W-1:0] rdata;
    logic [CNT_W-1:0]  widx;
    logic              we;

    assign widx = CNT_W'(i_data.term_index);
    assign we   = i_valid && o_ready && (i_data.cmd == CMD_WRITE)
                  && (widx < CNT_W'(MAX_TERMS));

    tpae_ram #(.W(TERM_W), .D(MAX_TERMS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (widx[AW-1:0]),
        .i_wdata ({i_data.coefficient, i_data.z_exponent,
                   i_data.y_exponent, i_data.x_exponent}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tpae_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_cmd_eval (i_data.cmd == CMD_EVAL),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_raddr    (raddr)
    );

    tpae_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_data),
        .i_rdata (rdata),
        .o_sts   (sts),
        .o_data  (o_data)
    );

endmodule

// File: rtl/tpae_chk.sv
// Port-level checker for the evaluator, bound to the top level.
module tpae_chk import tpae_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input t_in_item   i_data,
    input logic       o_valid,
    input logic       i_ready,
    input t_out_item  o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_data.cmd == CMD_WRITE) && !o_valid |=> !o_valid)
        else $error("write beat produced a result");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_data.cmd == CMD_EVAL) |=> !o_ready)
        else $error("input taken during evaluation");

endmodule

bind trivariate_poly_adjust_eval tpae_chk u_chk (.*);
